// ===== rtl/rqrle_pkg.sv =====
// Shared types and constants for the RGB quantize run-length encoder.
// No dependencies.
package rqrle_pkg;

    localparam int MAX_LINE_WIDTH = 4096;
    localparam int COL_W          = $clog2(MAX_LINE_WIDTH);
    localparam int LW_W           = $clog2(MAX_LINE_WIDTH + 1);
    localparam int LINE_WIDTH_RST = 640;

    localparam int COMP_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_FORMAT_MODE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LINE_WIDTH  = 1'd1;

    localparam logic FMT_RUN_LENGTH = 1'b0;
    localparam logic FMT_RAW        = 1'b1;

    localparam logic [BYTE_W-1:0] COUNT_MAX = 8'd255;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [BYTE_W-1:0] run_count;
        logic [BYTE_W-1:0] blue_out;
        logic [BYTE_W-1:0] green_out;
        logic [BYTE_W-1:0] red_out;
        logic              line_done;
        logic              last_of_item;
    } rec_t;

    typedef struct packed {
        logic v0;
        logic v1;
        rec_t r0;
        rec_t r1;
    } push_t;

endpackage

// ===== rtl/rqrle_quant.sv =====
// Quantizes one signed Q3.12 component to a byte, round half up, clamped 0..255.
// Depends on rqrle_pkg.
module rqrle_quant (
    input  logic [rqrle_pkg::COMP_W-1:0] comp_in,
    output logic [rqrle_pkg::BYTE_W-1:0] byte_out
);

    logic [24:0] ext;
    logic [24:0] t;

    always_comb begin
        ext = {{9{comp_in[rqrle_pkg::COMP_W-1]}}, comp_in};
        t   = (ext << 8) - ext + 25'd2048;
        if (t[24]) begin
            byte_out = '0;
        end else if (|t[23:20]) begin
            byte_out = rqrle_pkg::COUNT_MAX;
        end else begin
            byte_out = t[19:12];
        end
    end

endmodule

// ===== rtl/rqrle_encoder.sv =====
// Pixel input register, quantizers and run/line state; emits up to two records per item.
// Depends on rqrle_pkg and rqrle_quant.
module rqrle_encoder (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              pix_valid,
    output logic                              pix_ready,
    input  logic [rqrle_pkg::COMP_W-1:0]      red_in,
    input  logic [rqrle_pkg::COMP_W-1:0]      green_in,
    input  logic [rqrle_pkg::COMP_W-1:0]      blue_in,
    input  logic                              format_mode,
    input  logic [rqrle_pkg::LW_W-1:0]        line_width,
    input  logic                              room,
    output rqrle_pkg::push_t                  push
);

    logic                            valid_reg;
    logic [rqrle_pkg::COMP_W-1:0]    red_reg, green_reg, blue_reg;
    logic [23:0]                     held_colour_reg, held_colour_next;
    logic [rqrle_pkg::BYTE_W-1:0]    held_count_reg, held_count_next;
    logic [rqrle_pkg::COL_W-1:0]     column_reg, column_next;

    logic [rqrle_pkg::BYTE_W-1:0]    red_q, green_q, blue_q;
    logic [23:0]                     colour;
    logic [rqrle_pkg::LW_W-1:0]      column_inc;
    logic                            consume;
    logic                            line_end;
    logic                            held;
    logic                            extend;
    logic                            emit_held;
    logic                            emit_final;
    logic [rqrle_pkg::BYTE_W-1:0]    final_count;
    logic [23:0]                     final_colour;
    rqrle_pkg::rec_t                 held_rec, final_rec;

    rqrle_quant u_quant_r (.comp_in(red_reg),   .byte_out(red_q));
    rqrle_quant u_quant_g (.comp_in(green_reg), .byte_out(green_q));
    rqrle_quant u_quant_b (.comp_in(blue_reg),  .byte_out(blue_q));

    assign colour    = {red_q, green_q, blue_q};
    assign consume   = valid_reg && room;
    assign pix_ready = !valid_reg || room;

    always_comb begin
        column_inc = {1'b0, column_reg} + rqrle_pkg::LW_W'(1);
        line_end   = column_inc >= line_width;
        held       = held_count_reg != '0;
        extend     = held && (colour == held_colour_reg)
                     && (held_count_reg < rqrle_pkg::COUNT_MAX);

        held_colour_next = held_colour_reg;
        held_count_next  = held_count_reg;
        final_count      = 8'd1;
        final_colour     = colour;

        if (format_mode == rqrle_pkg::FMT_RAW) begin
            emit_held       = held;
            emit_final      = 1'b1;
            held_count_next = '0;
        end else begin
            emit_held  = held && !extend;
            emit_final = line_end;
            if (extend) begin
                held_count_next = held_count_reg + 8'd1;
            end else begin
                held_colour_next = colour;
                held_count_next  = 8'd1;
            end
            final_count  = held_count_next;
            final_colour = held_colour_next;
            if (line_end) begin
                held_count_next = '0;
            end
        end

        column_next = line_end ? '0 : column_inc[rqrle_pkg::COL_W-1:0];

        held_rec.run_count    = held_count_reg;
        held_rec.blue_out     = held_colour_reg[7:0];
        held_rec.green_out    = held_colour_reg[15:8];
        held_rec.red_out      = held_colour_reg[23:16];
        held_rec.line_done    = 1'b0;
        held_rec.last_of_item = !emit_final;

        final_rec.run_count    = final_count;
        final_rec.blue_out     = final_colour[7:0];
        final_rec.green_out    = final_colour[15:8];
        final_rec.red_out      = final_colour[23:16];
        final_rec.line_done    = line_end;
        final_rec.last_of_item = 1'b1;

        push.v0 = consume && (emit_held || emit_final);
        push.v1 = consume && emit_held && emit_final;
        push.r0 = emit_held ? held_rec : final_rec;
        push.r1 = final_rec;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= 1'b0;
            held_colour_reg <= '0;
            held_count_reg  <= '0;
            column_reg      <= '0;
        end else begin
            if (pix_valid && pix_ready) begin
                valid_reg <= 1'b1;
            end else if (consume) begin
                valid_reg <= 1'b0;
            end
            if (consume) begin
                held_colour_reg <= held_colour_next;
                held_count_reg  <= held_count_next;
                column_reg      <= column_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_valid && pix_ready) begin
            red_reg   <= red_in;
            green_reg <= green_in;
            blue_reg  <= blue_in;
        end
    end

endmodule

// ===== rtl/rqrle_fifo.sv =====
// Record queue: two writes and one read per cycle, registered entries.
// Depends on rqrle_pkg.
module rqrle_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  rqrle_pkg::push_t  push,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output rqrle_pkg::rec_t   out_rec
);

    rqrle_pkg::rec_t                  mem [rqrle_pkg::FIFO_DEPTH];
    logic [rqrle_pkg::PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [rqrle_pkg::PTR_W-1:0]      rd_ptr_reg;
    logic [rqrle_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [rqrle_pkg::PTR_W-1:0]      wr_ptr_inc;
    logic                             pop;

    assign out_valid  = count_reg != '0;
    assign out_rec    = mem[rd_ptr_reg];
    assign pop        = out_valid && out_ready;
    assign room       = count_reg <= rqrle_pkg::CNT_W'(rqrle_pkg::FIFO_DEPTH - 2);
    assign wr_ptr_inc = wr_ptr_reg + rqrle_pkg::PTR_W'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + rqrle_pkg::PTR_W'(push.v0) + rqrle_pkg::PTR_W'(push.v1);
        count_next  = count_reg + rqrle_pkg::CNT_W'(push.v0) + rqrle_pkg::CNT_W'(push.v1)
                      - rqrle_pkg::CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + rqrle_pkg::PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push.v0) begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.v1) begin
            mem[wr_ptr_inc] <= push.r1;
        end
    end

endmodule

// ===== rtl/rgb_quantize_run_length_encoder_core.sv =====
// Top level of the RGB quantize run-length encoder: config registers, encoder, record queue.
// Depends on rqrle_pkg, rqrle_encoder and rqrle_fifo.
//
//  Channel | Dir | Handshake         | Content
//  s_      | in  | s_tvalid/s_tready | one pixel, Q3.12 red/green/blue
//  m_      | out | m_tvalid/m_tready | one record; tlast = line end, tuser = last of item
//  cfg_    | in  | cfg_wen           | register write, no read-back
//
// One pixel per cycle while the record queue has room; the pixel register feeds quantizers
// and the run compare, which push zero, one or two records into a four-entry record queue.
// A pixel leaves its register only when the queue has two free entries.
// Synchronous active-low reset clears the run, column and queue; line width
// returns to 640 and the format to run-length records.
module rgb_quantize_run_length_encoder_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [47:0]                         s_tdata,  // red_in, green_in, blue_in
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [31:0]                         m_tdata,  // run_count, blue_out, green_out, red_out
    output logic                                m_tlast,  // line_done
    output logic                                m_tuser,  // last_of_item
    input  logic                                cfg_wen,
    input  logic [rqrle_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [rqrle_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    logic                           format_mode_reg;
    logic [rqrle_pkg::LW_W-1:0]     line_width_reg, line_width_next;
    logic                           room;
    rqrle_pkg::push_t               push;
    rqrle_pkg::rec_t                out_rec;

    always_comb begin
        if (cfg_wdata == '0) begin
            line_width_next = rqrle_pkg::LW_W'(1);
        end else if (32'(cfg_wdata) > rqrle_pkg::MAX_LINE_WIDTH) begin
            line_width_next = rqrle_pkg::LW_W'(rqrle_pkg::MAX_LINE_WIDTH);
        end else begin
            line_width_next = rqrle_pkg::LW_W'(cfg_wdata);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_mode_reg <= rqrle_pkg::FMT_RUN_LENGTH;
            line_width_reg  <= rqrle_pkg::LW_W'(rqrle_pkg::LINE_WIDTH_RST);
        end else if (cfg_wen) begin
            unique case (cfg_addr)
                rqrle_pkg::REG_FORMAT_MODE: format_mode_reg <= cfg_wdata[0];
                rqrle_pkg::REG_LINE_WIDTH:  line_width_reg  <= line_width_next;
                default: ;
            endcase
        end
    end

    rqrle_encoder u_encoder (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pix_valid   (s_tvalid),
        .pix_ready   (s_tready),
        .red_in      (s_tdata[15:0]),
        .green_in    (s_tdata[31:16]),
        .blue_in     (s_tdata[47:32]),
        .format_mode (format_mode_reg),
        .line_width  (line_width_reg),
        .room        (room),
        .push        (push)
    );

    rqrle_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rec   (out_rec)
    );

    assign m_tdata = {out_rec.red_out, out_rec.green_out, out_rec.blue_out, out_rec.run_count};
    assign m_tlast = out_rec.line_done;
    assign m_tuser = out_rec.last_of_item;

endmodule
